// ===== rtl/stx_crlf_status_frame_deframer_unit_macros.svh =====
// Assertion macros for the status frame deframer.
`ifndef STX_CRLF_STATUS_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define STX_CRLF_STATUS_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Checked only while out of reset.
`define STXDEFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define STXDEFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/stxdefr_pkg.sv =====
`timescale 1ns / 1ps

package stxdefr_pkg;

    localparam int FRAME_LEN = 18;
    localparam int CNT_W     = 5;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);

    localparam logic [7:0] SOF_S = 8'h53;
    localparam logic [7:0] SOF_T = 8'h54;
    localparam logic [7:0] SOF_X = 8'h58;
    localparam logic [7:0] EOF_CR = 8'h0D;
    localparam logic [7:0] EOF_LF = 8'h0A;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [7:0]         ctrl_mode;
        logic [7:0]         emergency_stop;
        logic [7:0]         gear;
        logic [15:0]        speed;
        logic signed [15:0] steer;
        logic [7:0]         brake;
        logic signed [31:0] encoder;
    } status_t;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] fill;
    } win_info_t;

    typedef struct packed {
        logic skid_full;
    } out_info_t;

endpackage

// ===== rtl/stxdefr_window.sv =====
`timescale 1ns / 1ps

module stxdefr_window (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_fire,
    input  stxdefr_pkg::byte_t     in_byte,
    output stxdefr_pkg::status_t   status,
    output stxdefr_pkg::win_info_t info
);
    import stxdefr_pkg::*;

    byte_t            window_reg [FRAME_LEN];
    byte_t            window_next [FRAME_LEN];
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] fill_inc;
    logic             hit;

    always_comb begin
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            window_next[i] = window_reg[i+1];
        end
        window_next[FRAME_LEN-1] = in_byte;
    end

    assign fill_inc = (fill_reg < CNT_FULL) ? fill_reg + CNT_W'(1) : fill_reg;

    assign hit = (fill_inc == CNT_FULL)
              && (window_next[0] == SOF_S)
              && (window_next[1] == SOF_T)
              && (window_next[2] == SOF_X)
              && (window_next[FRAME_LEN-2] == EOF_CR)
              && (window_next[FRAME_LEN-1] == EOF_LF);

    // Byte 15 carries no status.
    always_comb begin
        status.ctrl_mode      = window_next[3];
        status.emergency_stop = window_next[4];
        status.gear           = window_next[5];
        status.speed          = {window_next[7], window_next[6]};
        status.steer          = $signed({window_next[9], window_next[8]});
        status.brake          = window_next[10];
        status.encoder        = $signed({window_next[14], window_next[13],
                                         window_next[12], window_next[11]});
    end

    // A good frame restarts the count so none of its bytes starts another.
    assign fill_next = hit ? '0 : fill_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (in_fire) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                window_reg[i] <= window_next[i];
            end
        end
    end

    assign info.hit  = hit;
    assign info.fill = fill_reg;

endmodule

// ===== rtl/stxdefr_out_reg.sv =====
`timescale 1ns / 1ps

module stxdefr_out_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  stxdefr_pkg::status_t   push_data,
    input  logic                   m_ready,
    output logic                   m_valid,
    output stxdefr_pkg::status_t   m_data,
    output stxdefr_pkg::out_info_t info
);
    import stxdefr_pkg::*;

    status_t out_reg,  out_next;
    status_t skid_reg, skid_next;
    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            // drain skid first; no push can arrive while it is full
            if (out_free) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (out_free) begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (out_free) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_data         = out_reg;
    assign info.skid_full = skid_valid_reg;

endmodule

// ===== rtl/stx_crlf_status_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// A status result is registered on the transfer of the LF that closes its frame.
// One byte per cycle when skid is free, set by the 18-byte shift window and parallel compare.
// The two-entry result stage (output register plus skid) keeps input open while a result waits.
// Reset (aresetn low, synchronous): byte count and result valids clear; window bytes are not
// cleared, since no frame can match before 18 new bytes have arrived.

`include "stx_crlf_status_frame_deframer_unit_macros.svh"

module stx_crlf_status_frame_deframer_unit (
    input  logic               aclk,
    input  logic               aresetn,
    // byte input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    // status result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_ctrl_mode,
    output logic [7:0]         m_emergency_stop,
    output logic [7:0]         m_gear,
    output logic [15:0]        m_speed,
    output logic signed [15:0] m_steer,
    output logic [7:0]         m_brake,
    output logic signed [31:0] m_encoder
);
    import stxdefr_pkg::*;

    logic      s_fire;
    status_t   win_status;
    win_info_t win_info;
    status_t   res_data;
    out_info_t out_info;

    // Input is held off only when the skid entry is occupied; otherwise every
    // byte transfer is taken, even while a finished result waits on m_ready.
    assign s_ready = !out_info.skid_full;
    assign s_fire  = s_valid && s_ready;

    // Sliding window: shift in the byte, advance the fill count, and compare
    // header 'S','T','X' and trailer CR LF on the shifted window.
    stxdefr_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (s_fire),
        .in_byte (s_rx_byte),
        .status  (win_status),
        .info    (win_info)
    );

    // Result stage: capture the decoded status on a frame hit; overflow into
    // the skid entry when the output register is stalled.
    stxdefr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_fire && win_info.hit),
        .push_data (win_status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (res_data),
        .info      (out_info)
    );

    // Fan the result struct out to the field ports.
    assign m_ctrl_mode      = res_data.ctrl_mode;
    assign m_emergency_stop = res_data.emergency_stop;
    assign m_gear           = res_data.gear;
    assign m_speed          = res_data.speed;
    assign m_steer          = res_data.steer;
    assign m_brake          = res_data.brake;
    assign m_encoder        = res_data.encoder;

    // A full skid entry means the output register also holds a result.
    `STXDEFR_ASSERT(a_skid_implies_out, !s_ready |-> m_valid, "skid full with empty output")
    // A frame hit needs at least 17 bytes already counted (the count saturates at 18).
    `STXDEFR_ASSERT(a_hit_needs_fill, (s_fire && win_info.hit) |-> (win_info.fill >= CNT_LAST),
        "frame hit before window filled")
    // Every accepted frame hit is followed next cycle by m_valid (its result may wait in the skid).
    `STXDEFR_ASSERT(a_hit_gives_result, (s_fire && win_info.hit) |=> m_valid,
        "frame hit lost")
    // Reset empties the result stage and opens the input.
    `STXDEFR_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> (!m_valid && s_ready),
        "result stage not cleared by reset")

endmodule
